[design/ofx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofx_pkg: shared types, widths and tables of the odometry frame transform
// Holds the action codes, the datapath widths, the CORDIC arctangent table
// and the saturation helper used by the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package ofx_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_ADJUST = 2'd2;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam int POS_W  = 32;   // 1/16 mm positions
    localparam int HEAD_W = 16;   // binary angle
    localparam int TRIG_W = 18;   // Q2.16 sine and cosine
    localparam int OPND_W = 33;   // position differences and targets
    localparam int ACC_W  = 53;   // sum of two 33x18 products plus rounding
    localparam int CRD_W  = 34;   // Q2.30 CORDIC vector and angle

    localparam logic signed [CRD_W-1:0]  CORDIC_START_X = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE       = 18'sd65536;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;   // capture a new product
        logic acc_en;   // fold the held product into the accumulator
        logic clear;    // start a new sum with this product
        logic neg;      // subtract this product
    } ofx_mac_ctl_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CRD_W-1:0] atan_turns(input logic [4:0] idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to 32 bits signed
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/ofx_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofx_cordic: iterative CORDIC sine and cosine
// Rotates a gain-compensated unit vector by a 16-bit binary angle, one
// micro-rotation per cycle, and returns Q2.16 cosine and sine.
// ----------------------------------------------------------------------------
module ofx_cordic #(
    parameter int CORDIC_STEPS = ofx_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ofx_pkg::HEAD_W-1:0]          angle,
    output logic                                done,
    output logic signed [ofx_pkg::TRIG_W-1:0]   cos_q16,
    output logic signed [ofx_pkg::TRIG_W-1:0]   sin_q16
);
    import ofx_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    flip_reg, flip_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    logic signed [CRD_W-1:0] x_reg, x_next;
    logic signed [CRD_W-1:0] y_reg, y_next;
    logic signed [CRD_W-1:0] z_reg, z_next;
    logic signed [CRD_W-1:0] dx, dy, at;
    logic [HEAD_W-1:0]       ang_fold;
    logic signed [TRIG_W-1:0] cq, sq;

    // Bring Q2.30 to Q2.16, round half up and clamp
    function automatic logic signed [TRIG_W-1:0] q30_to_q16(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W:0]  t;
        logic signed [CRD_W-14:0] s;
        logic signed [TRIG_W-1:0] r;
        t = (CRD_W+1)'(v) + 35'sd8192;
        s = t[CRD_W:14];
        if (s > 21'sd131071) begin
            r = 18'sd131071;
        end else if (s < -21'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = s[TRIG_W-1:0];
        end
        return r;
    endfunction

    // Fold the angle into the right half plane by turning it half a turn
    assign ang_fold = (angle[15] ^ angle[14]) ? {~angle[15], angle[14:0]} : angle;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = atan_turns(5'(cnt_reg));

    // Load on start, then one micro-rotation per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        flip_next = flip_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            flip_next = angle[15] ^ angle[14];
            cnt_next  = '0;
            x_next    = CORDIC_START_X;
            y_next    = '0;
            z_next    = {{2{ang_fold[15]}}, ang_fold, 16'b0};
        end else if (busy_reg) begin
            if (!z_reg[CRD_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        flip_reg <= flip_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    // Undo the half-turn fold on the results
    assign cq      = q30_to_q16(x_reg);
    assign sq      = q30_to_q16(y_reg);
    assign cos_q16 = flip_reg ? -cq : cq;
    assign sin_q16 = flip_reg ? -sq : sq;
    assign done    = done_reg;

endmodule

[design/ofx_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofx_mac: shared multiply-accumulate unit
// One signed 33x18 multiplier with a product register, followed by an add or
// subtract into a wide accumulator.
// ----------------------------------------------------------------------------
module ofx_mac (
    input  logic                               aclk,
    input  ofx_pkg::ofx_mac_ctl_t              ctl,
    input  logic signed [ofx_pkg::OPND_W-1:0]  mul_a,
    input  logic signed [ofx_pkg::TRIG_W-1:0]  mul_b,
    output logic signed [ofx_pkg::ACC_W-1:0]   acc
);
    import ofx_pkg::*;

    localparam int PROD_W = OPND_W + TRIG_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  term, base;

    // Add or subtract the held product, or start a new sum
    always_comb begin
        term     = ACC_W'(prod_reg);
        base     = ctl.clear ? '0 : acc_reg;
        acc_next = ctl.neg ? (base - term) : (base + term);
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (ctl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[design/odometry_frame_transform.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_frame_transform: raw odometry to corrected world frame
// Top level: sequencer, pose and origin state, CORDIC and shared MAC.
// ----------------------------------------------------------------------------
// Each input word carries an action and a pose, and each returns one word with
// the current world pose. A raw sample (action 0) is stored and rotated into
// the world frame by the origin, with four passes through the single shared
// multiplier. Set (action 1) and adjust (action 2) move the origin so the
// stored raw pose maps to the target; they run the one-step-per-cycle CORDIC
// followed by the four multiplies. Set and adjust return the world pose of the
// last sample; the new origin applies from the next sample on. Code 3 changes
// nothing and returns the current world pose. The block takes one word at a
// time; s_ready is high only while it is idle, and a finished result waits in
// the output register without blocking the next word.
module odometry_frame_transform #(
    parameter int CORDIC_STEPS = ofx_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic signed [ofx_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [ofx_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [ofx_pkg::HEAD_W-1:0]  s_pos_heading,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ofx_pkg::POS_W-1:0]   m_world_x,
    output logic signed [ofx_pkg::POS_W-1:0]   m_world_y,
    output logic signed [ofx_pkg::HEAD_W-1:0]  m_world_heading
);
    import ofx_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CSTART,
        ST_TRIG,
        ST_MAC,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] mstep_reg, mstep_next;
    logic       is_set_reg, is_set_next;
    logic       m_valid_reg, m_valid_next;

    logic signed [POS_W-1:0]  raw_x_reg, raw_x_next, raw_y_reg, raw_y_next;
    logic [HEAD_W-1:0]        raw_h_reg, raw_h_next;
    logic signed [POS_W-1:0]  org_x_reg, org_x_next, org_y_reg, org_y_next;
    logic [HEAD_W-1:0]        org_h_reg, org_h_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next, cos_reg, cos_next;
    logic signed [POS_W-1:0]  cor_x_reg, cor_x_next, cor_y_reg, cor_y_next;
    logic [HEAD_W-1:0]        cor_h_reg, cor_h_next;
    logic signed [OPND_W-1:0] op_a_reg, op_a_next, op_b_reg, op_b_next;
    logic signed [POS_W-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [HEAD_W-1:0]        out_h_reg, out_h_next;

    logic                     accept;
    logic                     cordic_start, cordic_done;
    logic signed [TRIG_W-1:0] cordic_cos, cordic_sin;
    ofx_mac_ctl_t             mac_ctl;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [TRIG_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  acc, acc_rnd;
    logic signed [36:0]       rnd;
    logic signed [37:0]       org_diff;
    logic signed [POS_W-1:0]  res_val;
    logic signed [POS_W-1:0]  adj_x, adj_y;
    logic [1:0]               mul_term, acc_term;

    assign accept = s_valid && s_ready;

    ofx_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (org_h_reg),
        .done    (cordic_done),
        .cos_q16 (cordic_cos),
        .sin_q16 (cordic_sin)
    );

    // Term order: a*cos, b*sin, a*sin, b*cos
    assign mul_term = mstep_reg[1:0];
    assign acc_term = 2'(mstep_reg - 3'd1);

    always_comb begin
        mul_a = (mul_term[0]) ? op_b_reg : op_a_reg;
        mul_b = (mul_term == 2'd0 || mul_term == 2'd3) ? cos_reg : sin_reg;
        mac_ctl.mul_en = (state_reg == ST_MAC) && (mstep_reg < 3'd4);
        mac_ctl.acc_en = (state_reg == ST_MAC) && (mstep_reg >= 3'd1) && (mstep_reg <= 3'd4);
        mac_ctl.clear  = !acc_term[0];
        // Sample: x = a*c - b*s, y = a*s + b*c; set: x = a*c + b*s, y = -a*s + b*c
        mac_ctl.neg    = ((acc_term == 2'd1) && !is_set_reg) ||
                         ((acc_term == 2'd2) && is_set_reg);
    end

    ofx_mac u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .acc   (acc)
    );

    // Round half up out of Q16, then saturate, or subtract from the raw pose and saturate
    assign acc_rnd = acc + 53'sd32768;
    assign rnd     = acc_rnd[ACC_W-1:16];

    always_comb begin
        if (mstep_reg == 3'd3) begin
            org_diff = 38'(raw_x_reg) - 38'(rnd);
        end else begin
            org_diff = 38'(raw_y_reg) - 38'(rnd);
        end
        res_val = is_set_reg ? sat32(40'(org_diff)) : sat32(40'(rnd));
    end

    // Adjust target: world pose plus delta
    assign adj_x = sat32(40'(33'(cor_x_reg) + 33'(s_pos_x)));
    assign adj_y = sat32(40'(33'(cor_y_reg) + 33'(s_pos_y)));

    // Sequencer and state updates
    always_comb begin
        state_next   = state_reg;
        mstep_next   = mstep_reg;
        is_set_next  = is_set_reg;
        m_valid_next = m_valid_reg;
        raw_x_next   = raw_x_reg;
        raw_y_next   = raw_y_reg;
        raw_h_next   = raw_h_reg;
        org_x_next   = org_x_reg;
        org_y_next   = org_y_reg;
        org_h_next   = org_h_reg;
        sin_next     = sin_reg;
        cos_next     = cos_reg;
        cor_x_next   = cor_x_reg;
        cor_y_next   = cor_y_reg;
        cor_h_next   = cor_h_reg;
        op_a_next    = op_a_reg;
        op_b_next    = op_b_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_h_next   = out_h_reg;
        cordic_start = 1'b0;

        // Drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mstep_next = '0;
                    case (s_action)
                        ACT_SAMPLE: begin
                            raw_x_next  = s_pos_x;
                            raw_y_next  = s_pos_y;
                            raw_h_next  = s_pos_heading;
                            op_a_next   = 33'(s_pos_x) - 33'(org_x_reg);
                            op_b_next   = 33'(s_pos_y) - 33'(org_y_reg);
                            cor_h_next  = s_pos_heading + org_h_reg;
                            is_set_next = 1'b0;
                            state_next  = ST_MAC;
                        end
                        ACT_SET: begin
                            op_a_next   = 33'(s_pos_x);
                            op_b_next   = 33'(s_pos_y);
                            org_h_next  = s_pos_heading - raw_h_reg;
                            is_set_next = 1'b1;
                            state_next  = ST_CSTART;
                        end
                        ACT_ADJUST: begin
                            op_a_next   = 33'(adj_x);
                            op_b_next   = 33'(adj_y);
                            org_h_next  = cor_h_reg + s_pos_heading - raw_h_reg;
                            is_set_next = 1'b1;
                            state_next  = ST_CSTART;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CSTART: begin
                cordic_start = 1'b1;
                state_next   = ST_TRIG;
            end
            ST_TRIG: begin
                if (cordic_done) begin
                    cos_next   = cordic_cos;
                    sin_next   = cordic_sin;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                mstep_next = mstep_reg + 3'd1;
                if (mstep_reg == 3'd3) begin
                    if (is_set_reg) begin
                        org_x_next = res_val;
                    end else begin
                        cor_x_next = res_val;
                    end
                end
                if (mstep_reg == 3'd5) begin
                    if (is_set_reg) begin
                        org_y_next = res_val;
                    end else begin
                        cor_y_next = res_val;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_x_next   = cor_x_reg;
                    out_y_next   = cor_y_reg;
                    out_h_next   = cor_h_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mstep_reg   <= '0;
            is_set_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            raw_x_reg   <= '0;
            raw_y_reg   <= '0;
            raw_h_reg   <= '0;
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            org_h_reg   <= '0;
            sin_reg     <= '0;
            cos_reg     <= TRIG_ONE;
            cor_x_reg   <= '0;
            cor_y_reg   <= '0;
            cor_h_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            mstep_reg   <= mstep_next;
            is_set_reg  <= is_set_next;
            m_valid_reg <= m_valid_next;
            raw_x_reg   <= raw_x_next;
            raw_y_reg   <= raw_y_next;
            raw_h_reg   <= raw_h_next;
            org_x_reg   <= org_x_next;
            org_y_reg   <= org_y_next;
            org_h_reg   <= org_h_next;
            sin_reg     <= sin_next;
            cos_reg     <= cos_next;
            cor_x_reg   <= cor_x_next;
            cor_y_reg   <= cor_y_next;
            cor_h_reg   <= cor_h_next;
        end
        op_a_reg  <= op_a_next;
        op_b_reg  <= op_b_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_world_x       = out_x_reg;
    assign m_world_y       = out_y_reg;
    assign m_world_heading = out_h_reg;

    // A word in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a word was in flight");

    // A result word appears only out of the final sequencer step
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the final step");

    // CORDIC completes only while the sequencer waits on it
    a_cordic_in_trig: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_done |-> (state_reg == ST_TRIG))
        else $error("CORDIC finished outside its wait step");

    // MAC step count stays within its six steps
    a_mac_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (mstep_reg <= 3'd5))
        else $error("MAC step count out of range");

endmodule
